/* design/soa_pkg.sv */
// ----------------------------------------------------------------------------
// Slab object allocator package
// Shared constants, types and the per-class geometry helper.
// ----------------------------------------------------------------------------
package soa_pkg;

    localparam int PageBytes   = 4096;
    localparam int HeaderBytes = 64;
    localparam int NumPages    = 64;
    localparam int NumClasses  = 7;

    localparam int PAGE_W   = 6;   // page index bits
    localparam int OFF_W    = 12;  // byte offset within a page
    localparam int SLOT_W   = 8;   // slot index bits
    localparam int CLS_W    = 3;
    localparam int CNT_W    = 16;
    localparam int ADDR_W   = 18;
    localparam int SLOT_AW  = PAGE_W + SLOT_W;

    localparam int MaxSlots = (PageBytes - HeaderBytes) / 16;

    localparam logic [SLOT_W-1:0] SLOT_NULL = '1;
    localparam logic [PAGE_W:0]   PAGE_NULL = 7'(NumPages);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_LARGE     = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED = 3'd3;
    localparam logic [2:0] ST_BADFREE   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_CHECK,
        S_POP,
        S_INIT,
        S_FREE_CHK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [PAGE_W:0]   link;
        logic [CLS_W-1:0]  cls;
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] head;
    } page_ent_t;

    typedef struct packed {
        logic                pg_rd_en;
        logic [PAGE_W-1:0]   pg_rd_addr;
        logic                pg_wr_en;
        logic [PAGE_W-1:0]   pg_wr_addr;
        page_ent_t           pg_wr_data;
        logic                sl_rd_en;
        logic [SLOT_AW-1:0]  sl_rd_addr;
        logic                sl_wr_en;
        logic [SLOT_AW-1:0]  sl_wr_addr;
        logic [SLOT_W-1:0]   sl_wr_data;
    } mem_req_t;

    typedef struct packed {
        page_ent_t           pg_rd_data;
        logic [SLOT_W-1:0]   sl_rd_data;
    } mem_rsp_t;

    // Number of slots in a page of the given class.
    function automatic logic [SLOT_W-1:0] slots_in_page(input logic [CLS_W-1:0] cls);
        logic [OFF_W-1:0] room;
        room = OFF_W'(PageBytes - HeaderBytes);
        return SLOT_W'(room >> ({1'b0, cls} + 4'd4));
    endfunction

endpackage

/* design/slab_object_allocator_core.sv */
// ----------------------------------------------------------------------------
// Slab object allocator core: one item at a time. A reject goes straight to
// the response state; an alloc walks the class list (read, check) to a page
// with a free slot and pops it, or takes a new page and sweeps its slot links
// (3 to 252 slots); a free checks the page descriptor first. Reset empties all class lists and the pool.
// ----------------------------------------------------------------------------
module slab_object_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // request_size[15:0], free_address[33:16], zero fill
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // object_address[17:0], size_class[20:18], status[23:21]
);
    import soa_pkg::*;

    state_t            state_reg, state_next;
    logic [CLS_W-1:0]  cls_reg, cls_next;
    logic [PAGE_W:0]   page_reg, page_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [CLS_W-1:0]  res_cls_reg, res_cls_next;
    logic [2:0]        res_st_reg, res_st_next;
    logic [PAGE_W:0]   taken_reg, taken_next;
    logic [PAGE_W:0]   head_reg [NumClasses];
    logic              head_we;
    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;

    mem_req_t req;
    mem_rsp_t rsp;

    soa_store u_store (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    logic [15:0]       in_size;
    logic [ADDR_W-1:0] in_addr;
    logic [15:0]       eff_size;
    logic [CLS_W-1:0]  in_cls;
    logic              in_large;
    logic [SLOT_W-1:0] total;
    logic              accept;
    logic              free_pre_ok;
    logic              page_ok;
    logic [OFF_W-1:0]  rel;
    logic [OFF_W-1:0]  rel_mask;
    logic [3:0]        rd_shift;
    logic [SLOT_W-1:0] free_slot;
    logic              free_ok;

    assign in_size  = s_tdata[15:0];
    assign in_addr  = s_tdata[33:16];
    assign accept   = s_tvalid && s_tready;
    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Smallest class that holds the rounded-up size.
    always_comb begin
        eff_size = (in_size < 16'd16) ? 16'd16 : in_size;
        in_cls   = '0;
        in_large = 1'b1;
        for (int c = NumClasses - 1; c >= 0; c--) begin
            if (eff_size <= (16'd16 << c)) begin
                in_cls   = CLS_W'(c);
                in_large = 1'b0;
            end
        end
    end

    assign total       = slots_in_page(cls_reg);
    assign free_pre_ok = ({1'b0, in_addr[ADDR_W-1:OFF_W]} < taken_reg)
                         && (in_addr[OFF_W-1:0] >= OFF_W'(HeaderBytes));
    assign page_ok     = (rsp.pg_rd_data.count != '0)
                         && (rsp.pg_rd_data.head < SLOT_W'(MaxSlots));
    assign rel         = off_reg - OFF_W'(HeaderBytes);
    assign rel_mask    = (OFF_W'(16) << rsp.pg_rd_data.cls) - OFF_W'(1);
    assign rd_shift    = {1'b0, rsp.pg_rd_data.cls} + 4'd4;
    assign free_slot   = SLOT_W'(rel >> rd_shift);
    assign free_ok     = ((rel & rel_mask) == '0)
                         && ((rel >> rd_shift) <
                             OFF_W'(slots_in_page(rsp.pg_rd_data.cls)));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser == KIND_FREE) begin
                        state_next = free_pre_ok ? S_FREE_CHK : S_RESP;
                    end else if (in_size == '0 || in_large) begin
                        state_next = S_RESP;
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (page_reg[PAGE_W]) begin
                    state_next = (taken_reg >= PAGE_NULL) ? S_RESP : S_INIT;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:    state_next = page_ok ? S_POP : S_WALK;
            S_POP:      state_next = S_RESP;
            S_INIT:     state_next = (idx_reg == total - 1'b1) ? S_RESP : S_INIT;
            S_FREE_CHK: state_next = S_RESP;
            S_RESP:     state_next = (!m_tvalid_reg || m_tready) ? S_IDLE : S_RESP;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and memory requests.
    always_comb begin
        cls_next      = cls_reg;
        page_next     = page_reg;
        idx_next      = idx_reg;
        off_next      = off_reg;
        res_addr_next = res_addr_reg;
        res_cls_next  = res_cls_reg;
        res_st_next   = res_st_reg;
        taken_next    = taken_reg;
        head_we       = 1'b0;
        req           = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_addr_next = '0;
                    res_cls_next  = '0;
                    off_next      = in_addr[OFF_W-1:0];
                    page_next     = {1'b0, in_addr[ADDR_W-1:OFF_W]};
                    if (s_tuser == KIND_FREE) begin
                        res_st_next    = ST_BADFREE;
                        req.pg_rd_en   = 1'b1;
                        req.pg_rd_addr = in_addr[ADDR_W-1:OFF_W];
                    end else if (in_size == '0) begin
                        res_st_next = ST_ZERO;
                    end else if (in_large) begin
                        res_st_next = ST_LARGE;
                    end else begin
                        cls_next  = in_cls;
                        page_next = head_reg[in_cls];
                    end
                end
            end
            S_WALK: begin
                if (page_reg[PAGE_W]) begin
                    res_cls_next = cls_reg;
                    res_st_next  = ST_EXHAUSTED;
                    page_next    = taken_reg;
                    idx_next     = '0;
                end else begin
                    req.pg_rd_en   = 1'b1;
                    req.pg_rd_addr = page_reg[PAGE_W-1:0];
                end
            end
            S_CHECK: begin
                if (page_ok) begin
                    req.sl_rd_en   = 1'b1;
                    req.sl_rd_addr = {page_reg[PAGE_W-1:0], rsp.pg_rd_data.head};
                end else begin
                    page_next = rsp.pg_rd_data.link;
                end
            end
            S_POP: begin
                req.pg_wr_en           = 1'b1;
                req.pg_wr_addr         = page_reg[PAGE_W-1:0];
                req.pg_wr_data         = rsp.pg_rd_data;
                req.pg_wr_data.head    = rsp.sl_rd_data;
                req.pg_wr_data.count   = rsp.pg_rd_data.count - 1'b1;
                res_addr_next = {page_reg[PAGE_W-1:0],
                                 OFF_W'(HeaderBytes) +
                                 OFF_W'({4'd0, rsp.pg_rd_data.head, 4'd0} << cls_reg)};
                res_cls_next  = cls_reg;
                res_st_next   = ST_OK;
            end
            S_INIT: begin
                req.sl_wr_en   = 1'b1;
                req.sl_wr_addr = {page_reg[PAGE_W-1:0], idx_reg};
                idx_next       = idx_reg + 1'b1;
                if (idx_reg == total - 1'b1) begin
                    req.sl_wr_data = SLOT_NULL;
                    // Slot 0 is handed out at once, so the page starts popped.
                    req.pg_wr_en         = 1'b1;
                    req.pg_wr_addr       = page_reg[PAGE_W-1:0];
                    req.pg_wr_data.link  = head_reg[cls_reg];
                    req.pg_wr_data.cls   = cls_reg;
                    req.pg_wr_data.count = CNT_W'(total) - 1'b1;
                    req.pg_wr_data.head  = (total > SLOT_W'(1)) ? SLOT_W'(1) : SLOT_NULL;
                    head_we       = 1'b1;
                    taken_next    = taken_reg + 1'b1;
                    res_addr_next = {page_reg[PAGE_W-1:0], OFF_W'(HeaderBytes)};
                    res_cls_next  = cls_reg;
                    res_st_next   = ST_OK;
                end else begin
                    req.sl_wr_data = idx_reg + 1'b1;
                end
            end
            S_FREE_CHK: begin
                if (free_ok) begin
                    req.sl_wr_en         = 1'b1;
                    req.sl_wr_addr       = {page_reg[PAGE_W-1:0], free_slot};
                    req.sl_wr_data       = rsp.pg_rd_data.head;
                    req.pg_wr_en         = 1'b1;
                    req.pg_wr_addr       = page_reg[PAGE_W-1:0];
                    req.pg_wr_data       = rsp.pg_rd_data;
                    req.pg_wr_data.head  = free_slot;
                    req.pg_wr_data.count = rsp.pg_rd_data.count + 1'b1;
                    res_cls_next         = rsp.pg_rd_data.cls;
                    res_st_next          = ST_OK;
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            taken_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < NumClasses; c++) begin
                head_reg[c] <= PAGE_NULL;
            end
        end else begin
            state_reg <= state_next;
            taken_reg <= taken_next;
            if (head_we) begin
                head_reg[cls_reg] <= page_reg;
            end
            if (state_reg == S_RESP && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cls_reg      <= cls_next;
        page_reg     <= page_next;
        idx_reg      <= idx_next;
        off_reg      <= off_next;
        res_addr_reg <= res_addr_next;
        res_cls_reg  <= res_cls_next;
        res_st_reg   <= res_st_next;
        if (state_reg == S_RESP && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {res_st_reg, res_cls_reg, res_addr_reg};
        end
    end

endmodule

/* design/soa_store.sv */
// ----------------------------------------------------------------------------
// Slab allocator state store
// Page descriptor memory and per-slot free-list link memory, registered reads.
// ----------------------------------------------------------------------------
module soa_store (
    input  logic             aclk,
    input  soa_pkg::mem_req_t req,
    output soa_pkg::mem_rsp_t rsp
);
    import soa_pkg::*;

    page_ent_t         page_mem [NumPages];
    logic [SLOT_W-1:0] slot_mem [2**SLOT_AW];

    always_ff @(posedge aclk) begin
        if (req.pg_wr_en) begin
            page_mem[req.pg_wr_addr] <= req.pg_wr_data;
        end
        if (req.pg_rd_en) begin
            rsp.pg_rd_data <= page_mem[req.pg_rd_addr];
        end
        if (req.sl_wr_en) begin
            slot_mem[req.sl_wr_addr] <= req.sl_wr_data;
        end
        if (req.sl_rd_en) begin
            rsp.sl_rd_data <= slot_mem[req.sl_rd_addr];
        end
    end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Slab object allocator testbench
// Drives alloc and free items into the core and compares every result with
// a predictor that keeps its own copy of the class lists, pages and slots.
// ----------------------------------------------------------------------------
module tb_top;
    import soa_pkg::*;

    localparam int CycleLimit = 3000000;
    localparam int SlotsMax   = 252;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CLS_W-1:0]  cls;
        logic [2:0]        status;
    } alloc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    bit          steady = 1'b0;
    int          errors = 0;
    int          cycles = 0;
    int          status_seen[5];
    alloc_result_t pending_results[$];
    logic [ADDR_W-1:0] live_objects[$];

    // Predictor state.
    int class_first[NumClasses];
    int next_page[NumPages];
    int page_cls[NumPages];
    int avail_slots[NumPages];
    int free_first[NumPages];
    int next_slot[NumPages][SlotsMax];
    int used_pages;

    slab_object_allocator_core dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk)
        m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 32);

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[17:0] != want.addr)
                    report_mismatch("object_address", m_tdata[17:0], want.addr);
                if (m_tdata[20:18] != want.cls)
                    report_mismatch("size_class", m_tdata[20:18], want.cls);
                if (m_tdata[23:21] != want.status)
                    report_mismatch("status", m_tdata[23:21], want.status);
                status_seen[m_tdata[23:21] % 5]++;
            end
        end
    end

    function automatic int class_bytes(input int c);
        return 16 << c;
    endfunction

    function automatic alloc_result_t predict_alloc(input int size);
        alloc_result_t r;
        int c, p, n, total, slot;
        r = '0;
        if (size == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        if (size < 16) size = 16;
        for (c = 0; c < NumClasses; c++)
            if (size <= class_bytes(c)) break;
        if (c >= NumClasses) begin
            r.status = ST_LARGE;
            return r;
        end
        p = class_first[c];
        for (n = 0; n < NumPages && p < NumPages; n++) begin
            if (avail_slots[p] != 0 && free_first[p] != 'hFFFF && free_first[p] < SlotsMax)
                break;
            p = next_page[p];
        end
        r.cls = CLS_W'(c);
        if (n >= NumPages || p >= NumPages) begin
            total = (PageBytes - HeaderBytes) / class_bytes(c);
            if (used_pages >= NumPages || total == 0) begin
                r.status = ST_EXHAUSTED;
                return r;
            end
            p = used_pages++;
            for (int i = 0; i < total; i++)
                next_slot[p][i] = (i + 1 < total) ? i + 1 : 'hFFFF;
            page_cls[p] = c;
            avail_slots[p] = total;
            free_first[p] = 0;
            next_page[p] = class_first[c];
            class_first[c] = p;
        end
        slot = free_first[p];
        free_first[p] = next_slot[p][slot];
        avail_slots[p] = (avail_slots[p] - 1) & 'hFFFF;
        r.addr = ADDR_W'(p * PageBytes + HeaderBytes + slot * class_bytes(c));
        r.status = ST_OK;
        return r;
    endfunction

    function automatic alloc_result_t predict_free(input int addr);
        alloc_result_t r;
        int p, off, c, rel, slot;
        r = '0;
        r.status = ST_BADFREE;
        p = addr / PageBytes;
        off = addr % PageBytes;
        if (p >= used_pages || p >= NumPages || off < HeaderBytes) return r;
        c = page_cls[p];
        rel = off - HeaderBytes;
        if (rel % class_bytes(c) != 0) return r;
        slot = rel / class_bytes(c);
        if (slot >= (PageBytes - HeaderBytes) / class_bytes(c) || slot >= SlotsMax) return r;
        next_slot[p][slot] = free_first[p];
        free_first[p] = slot;
        avail_slots[p] = (avail_slots[p] + 1) & 'hFFFF;
        r.cls = CLS_W'(c);
        r.status = ST_OK;
        return r;
    endfunction

    // Sends one item and records the result it must produce.
    task automatic send_item(input logic kind, input int size, input int addr);
        alloc_result_t r;
        if (!steady && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, 18'(addr), 16'(size)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == KIND_ALLOC) begin
            r = predict_alloc(size);
            if (r.status == ST_OK) live_objects.push_back(r.addr);
        end else begin
            r = predict_free(addr);
        end
        pending_results.push_back(r);
    endtask

    task automatic test_rejects();
        send_item(KIND_ALLOC, 0, 'h3FFFF);
        send_item(KIND_ALLOC, 1025, 0);
        send_item(KIND_ALLOC, 65535, 0);
        send_item(KIND_FREE, 'hFFFF, 0);
        send_item(KIND_FREE, 0, 'h3FFFF);
        send_item(KIND_FREE, 0, HeaderBytes);
    endtask

    task automatic test_classes();
        int sizes[] = '{1, 15, 16, 17, 32, 33, 64, 100, 128, 256, 257, 512, 1000, 1024};
        foreach (sizes[i]) send_item(KIND_ALLOC, sizes[i], 0);
    endtask

    // Page 0 holds 16-byte objects; the last class-6 page has three slots.
    task automatic test_free_cases();
        send_item(KIND_FREE, 0, HeaderBytes + 8);
        send_item(KIND_FREE, 0, 12);
        send_item(KIND_FREE, 0, 6 * PageBytes + HeaderBytes + 3 * 1024);
        send_item(KIND_FREE, 0, HeaderBytes);
        send_item(KIND_FREE, 0, HeaderBytes);
        send_item(KIND_ALLOC, 16, 0);
    endtask

    task automatic test_random(input int count);
        int idx, size, pick;
        for (int i = 0; i < count; i++) begin
            steady = (i >= count / 2 && i < count / 2 + 200);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                case ($urandom_range(0, 9))
                    0: size = $urandom_range(0, 65535);
                    1: size = $urandom_range(1024, 1100);
                    2, 3, 4: size = $urandom_range(1, 64);
                    default: size = $urandom_range(1, 1024);
                endcase
                send_item(KIND_ALLOC, size, $urandom_range(0, 'h3FFFF));
            end else if (pick < 88 && live_objects.size() > 0) begin
                idx = $urandom_range(0, live_objects.size() - 1);
                send_item(KIND_FREE, $urandom_range(0, 65535), live_objects[idx]);
                // Now and then leave it live so that it is freed twice.
                if ($urandom_range(0, 49) != 0) live_objects.delete(idx);
            end else begin
                send_item(KIND_FREE, $urandom_range(0, 65535),
                          ($urandom_range(0, 1) ? $urandom_range(0, 'h3FFFF)
                                                : $urandom_range(0, 'hFFFF)));
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        for (int c = 0; c < NumClasses; c++) class_first[c] = NumPages;
        used_pages = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_rejects();
        test_classes();
        test_free_cases();
        test_random(2000);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("covered ok %0d, zero %0d, too large %0d, exhausted %0d, bad free %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        $display("pages taken %0d of %0d, %0d cycles", used_pages, NumPages, cycles);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/soa_pkg.sv
design/soa_store.sv
design/slab_object_allocator_core.sv
sim/tb_top.sv
